// ----- design/readers_writer_lock_arbiter_core_macros.svh -----
// Assertion helpers for the lock arbiter RTL.
`ifndef READERS_WRITER_LOCK_ARBITER_CORE_MACROS_SVH
`define READERS_WRITER_LOCK_ARBITER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RWL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RWL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/rwl_pkg.sv -----
package rwl_pkg;

  localparam int NUM_REQUESTERS = 64;
  localparam int QUEUE_DEPTH    = 16;

  localparam int OP_W  = 2;
  localparam int ID_W  = 6;
  localparam int EV_W  = 3;
  localparam int CNT_W = 7;

  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int QSUM_W = QPTR_W + 1;

  localparam int READER_LIMIT = (NUM_REQUESTERS < 127) ? NUM_REQUESTERS : 127;

  localparam int S_DATA_W     = 8;
  localparam int OUT_FIELDS_W = EV_W + ID_W + CNT_W + 1;
  localparam int M_DATA_W     = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_ENTER_READ  = 2'd0,
    OP_ENTER_WRITE = 2'd1,
    OP_EXIT_READ   = 2'd2,
    OP_EXIT_WRITE  = 2'd3
  } op_t;

  typedef enum logic [EV_W-1:0] {
    EV_GRANTED      = 3'd0,
    EV_QUEUED       = 3'd1,
    EV_WRITER_WOKEN = 3'd2,
    EV_READER_WOKEN = 3'd3,
    EV_RELEASED     = 3'd4,
    EV_FULL         = 3'd5,
    EV_NO_HOLDER    = 3'd6
  } event_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DRAIN
  } state_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic single;
  } fifo_stat_t;

  typedef struct packed {
    logic zero;
    logic at_limit;
    logic dec_zero;
  } cnt_stat_t;

endpackage

// ----- design/rwl_fifo.sv -----
module rwl_fifo (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  logic                     pop,
  input  logic [rwl_pkg::ID_W-1:0] wr_data,
  output logic [rwl_pkg::ID_W-1:0] rd_data,
  output rwl_pkg::fifo_stat_t      stat
);

  logic [rwl_pkg::ID_W-1:0]   mem [rwl_pkg::QUEUE_DEPTH];
  logic [rwl_pkg::QPTR_W-1:0] head;
  logic [rwl_pkg::QPTR_W-1:0] head_next;
  logic [rwl_pkg::QCNT_W-1:0] count;
  logic [rwl_pkg::QSUM_W-1:0] slot_sum;
  logic [rwl_pkg::QPTR_W-1:0] wr_slot;

  assign slot_sum = rwl_pkg::QSUM_W'(head) + rwl_pkg::QSUM_W'(count);
  assign wr_slot  = (slot_sum >= rwl_pkg::QSUM_W'(rwl_pkg::QUEUE_DEPTH)) ?
                    rwl_pkg::QPTR_W'(slot_sum - rwl_pkg::QSUM_W'(rwl_pkg::QUEUE_DEPTH)) :
                    rwl_pkg::QPTR_W'(slot_sum);

  always_comb begin
    head_next = head;
    if (pop) begin
      if (head == rwl_pkg::QPTR_W'(rwl_pkg::QUEUE_DEPTH - 1)) begin
        head_next = '0;
      end else begin
        head_next = head + 1'b1;
      end
    end
  end

  assign stat.empty  = (count == '0);
  assign stat.full   = (count == rwl_pkg::QCNT_W'(rwl_pkg::QUEUE_DEPTH));
  assign stat.single = (count == rwl_pkg::QCNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head <= head_next;
      if (push) begin
        count <= count + 1'b1;
      end else if (pop) begin
        count <= count - 1'b1;
      end
    end
  end

  // rd_data always shows the entry at the head; bypass a write into the head slot
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_slot] <= wr_data;
    end
    if (push && (wr_slot == head_next)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[head_next];
    end
  end

endmodule

// ----- design/rwl_count_unit.sv -----
module rwl_count_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  rwl_pkg::cnt_op_t          mode,
  output logic [rwl_pkg::CNT_W-1:0] count_next,
  output rwl_pkg::cnt_stat_t        stat
);

  logic [rwl_pkg::CNT_W-1:0] count;

  assign stat.zero     = (count == '0);
  assign stat.at_limit = (count >= rwl_pkg::CNT_W'(rwl_pkg::READER_LIMIT));
  assign stat.dec_zero = (count == rwl_pkg::CNT_W'(1));

  // saturating increment, decrement that stops at zero
  always_comb begin
    count_next = count;
    case (mode)
      rwl_pkg::CNT_INC: begin
        if (!stat.at_limit) begin
          count_next = count + 1'b1;
        end
      end
      rwl_pkg::CNT_DEC: begin
        if (!stat.zero) begin
          count_next = count - 1'b1;
        end
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

// ----- design/readers_writer_lock_arbiter_core.sv -----
// Readers-writer lock arbiter, writer preference. A request is taken when s_tready is high
// and enters execution in the next cycle. Once the output register is free, a short request
// registers its single result and the block returns to idle. An exit write that hands
// the lock to N waiting readers gives no result of its own: the readers leave the reader
// queue memory one per cycle while the output register is free, through the one shared
// count unit, each giving its own result. The output register lets a new request be taken
// while the last result still waits for m_tready.
`include "readers_writer_lock_arbiter_core_macros.svh"

module readers_writer_lock_arbiter_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // [1:0] operation, [7:2] requester_id
  input  logic [rwl_pkg::S_DATA_W-1:0] s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // [2:0] event_res, [8:3] granted_id, [15:9] readers_active, [16] writer_active, rest zero
  output logic [rwl_pkg::M_DATA_W-1:0] m_tdata,
  output logic                         m_tlast
);

  rwl_pkg::state_t state, state_next;
  rwl_pkg::op_t    op_r;
  logic [rwl_pkg::ID_W-1:0] id_r;
  logic writer;
  logic writer_next;

  logic out_free;
  logic load;
  logic last_n;
  rwl_pkg::event_t ev;
  logic [rwl_pkg::ID_W-1:0] gid;

  logic rq_push, rq_pop, wq_push, wq_pop;
  logic [rwl_pkg::ID_W-1:0] rq_data, wq_data;
  rwl_pkg::fifo_stat_t rq_stat, wq_stat;

  rwl_pkg::cnt_op_t cnt_mode;
  logic [rwl_pkg::CNT_W-1:0] cnt_next;
  rwl_pkg::cnt_stat_t cnt_stat;

  rwl_fifo u_rq (
    .clk     (clk),
    .rst     (rst),
    .push    (rq_push),
    .pop     (rq_pop),
    .wr_data (id_r),
    .rd_data (rq_data),
    .stat    (rq_stat)
  );

  rwl_fifo u_wq (
    .clk     (clk),
    .rst     (rst),
    .push    (wq_push),
    .pop     (wq_pop),
    .wr_data (id_r),
    .rd_data (wq_data),
    .stat    (wq_stat)
  );

  rwl_count_unit u_cnt (
    .clk        (clk),
    .rst        (rst),
    .mode       (cnt_mode),
    .count_next (cnt_next),
    .stat       (cnt_stat)
  );

  assign s_tready = (state == rwl_pkg::ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    case (state)
      rwl_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = rwl_pkg::ST_EXEC;
        end
      end
      rwl_pkg::ST_EXEC: begin
        if (out_free) begin
          if (op_r == rwl_pkg::OP_EXIT_WRITE && writer && !rq_stat.empty) begin
            state_next = rwl_pkg::ST_DRAIN;
          end else begin
            state_next = rwl_pkg::ST_IDLE;
          end
        end
      end
      rwl_pkg::ST_DRAIN: begin
        if (out_free && rq_stat.single) begin
          state_next = rwl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rwl_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    rq_push     = 1'b0;
    rq_pop      = 1'b0;
    wq_push     = 1'b0;
    wq_pop      = 1'b0;
    cnt_mode    = rwl_pkg::CNT_HOLD;
    writer_next = writer;
    load        = 1'b0;
    ev          = rwl_pkg::EV_RELEASED;
    gid         = id_r;
    last_n      = 1'b1;
    case (state)
      rwl_pkg::ST_EXEC: begin
        if (out_free) begin
          load = 1'b1;
          case (op_r)
            rwl_pkg::OP_ENTER_READ: begin
              if (!wq_stat.empty || writer) begin
                if (rq_stat.full) begin
                  ev = rwl_pkg::EV_FULL;
                end else begin
                  rq_push = 1'b1;
                  ev      = rwl_pkg::EV_QUEUED;
                end
              end else if (cnt_stat.at_limit) begin
                ev = rwl_pkg::EV_FULL;
              end else begin
                cnt_mode = rwl_pkg::CNT_INC;
                ev       = rwl_pkg::EV_GRANTED;
              end
            end
            rwl_pkg::OP_ENTER_WRITE: begin
              if (!cnt_stat.zero || writer) begin
                if (wq_stat.full) begin
                  ev = rwl_pkg::EV_FULL;
                end else begin
                  wq_push = 1'b1;
                  ev      = rwl_pkg::EV_QUEUED;
                end
              end else begin
                writer_next = 1'b1;
                ev          = rwl_pkg::EV_GRANTED;
              end
            end
            rwl_pkg::OP_EXIT_READ: begin
              if (cnt_stat.zero) begin
                ev = rwl_pkg::EV_NO_HOLDER;
              end else begin
                cnt_mode = rwl_pkg::CNT_DEC;
                if (cnt_stat.dec_zero && !wq_stat.empty) begin
                  wq_pop      = 1'b1;
                  writer_next = 1'b1;
                  ev          = rwl_pkg::EV_WRITER_WOKEN;
                  gid         = wq_data;
                end
              end
            end
            rwl_pkg::OP_EXIT_WRITE: begin
              if (!writer) begin
                ev = rwl_pkg::EV_NO_HOLDER;
              end else if (rq_stat.empty && !wq_stat.empty) begin
                wq_pop = 1'b1;
                ev     = rwl_pkg::EV_WRITER_WOKEN;
                gid    = wq_data;
              end else begin
                writer_next = 1'b0;
                // waiting readers are released one per cycle in the drain state while the output register is free
                if (!rq_stat.empty) begin
                  load = 1'b0;
                end
              end
            end
            default: begin
              ev = rwl_pkg::EV_NO_HOLDER;
            end
          endcase
        end
      end
      rwl_pkg::ST_DRAIN: begin
        if (out_free) begin
          load     = 1'b1;
          rq_pop   = 1'b1;
          cnt_mode = rwl_pkg::CNT_INC;
          ev       = rwl_pkg::EV_READER_WOKEN;
          gid      = rq_data;
          last_n   = rq_stat.single;
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= rwl_pkg::ST_IDLE;
      writer   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state  <= state_next;
      writer <= writer_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_r <= rwl_pkg::op_t'(s_tdata[rwl_pkg::OP_W-1:0]);
      id_r <= s_tdata[rwl_pkg::OP_W +: rwl_pkg::ID_W];
    end
    if (load) begin
      m_tdata <= {(rwl_pkg::M_DATA_W - rwl_pkg::OUT_FIELDS_W)'(0),
                  writer_next, cnt_next, gid, ev};
      m_tlast <= last_n;
    end
  end

  `RWL_ASSERT_NOW(a_excl_hold, clk, rst, writer, cnt_stat.zero, "writer holds with readers active")
  `RWL_ASSERT_NOW(a_drain_no_writer, clk, rst, state == rwl_pkg::ST_DRAIN, !writer, "drain with writer")
  `RWL_ASSERT_NOW(a_drain_nonempty, clk, rst, state == rwl_pkg::ST_DRAIN, !rq_stat.empty, "drain on empty queue")
  `RWL_ASSERT_NEXT(a_last_idle, clk, rst, load && last_n, state == rwl_pkg::ST_IDLE, "no idle after last")

endmodule

// ----- tb/lock_event_checker.sv -----
`timescale 1ns / 100ps

module lock_event_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  // [1:0] operation, [7:2] requester_id
  input  logic [rwl_pkg::S_DATA_W-1:0] s_tdata,
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  // [2:0] event_res, [8:3] granted_id, [15:9] readers_active, [16] writer_active
  input  logic [rwl_pkg::M_DATA_W-1:0] m_tdata,
  input  logic                         m_tlast,
  output int                           fail_count,
  output int                           pending,
  output int                           requests_seen,
  output int                           results_seen,
  output logic [6:0]                   codes_seen,
  output logic [rwl_pkg::CNT_W-1:0]    readers_held,
  output logic                         writer_held
);
  import rwl_pkg::*;

  typedef struct {
    event_t             ev;
    logic [ID_W-1:0]    who;
    logic [CNT_W-1:0]   readers;
    logic               writer;
    logic               fin;
  } lock_event_t;

  lock_event_t expected_events[$];

  // shadow of the lock state
  logic [ID_W-1:0]   rd_wait [QUEUE_DEPTH];
  logic [ID_W-1:0]   wr_wait [QUEUE_DEPTH];
  logic [QPTR_W-1:0] rd_head, wr_head;
  logic [QCNT_W-1:0] rd_count, wr_count;
  logic [CNT_W-1:0]  lock_readers;
  logic              lock_writer;

  int         fails = 0;
  int         n_req = 0;
  int         n_res = 0;
  logic [6:0] hits = '0;

  task automatic post_event(input event_t ev, input logic [ID_W-1:0] who, input logic fin);
    lock_event_t e;
    e.ev      = ev;
    e.who     = who;
    e.readers = lock_readers;
    e.writer  = lock_writer;
    e.fin     = fin;
    expected_events.push_back(e);
  endtask

  task automatic enqueue_reader(input logic [ID_W-1:0] who);
    rd_wait[QPTR_W'((int'(rd_head) + int'(rd_count)) % QUEUE_DEPTH)] = who;
    rd_count = rd_count + 1'b1;
  endtask

  task automatic enqueue_writer(input logic [ID_W-1:0] who);
    wr_wait[QPTR_W'((int'(wr_head) + int'(wr_count)) % QUEUE_DEPTH)] = who;
    wr_count = wr_count + 1'b1;
  endtask

  task automatic dequeue_reader(output logic [ID_W-1:0] who);
    who      = rd_wait[rd_head];
    rd_head  = QPTR_W'((int'(rd_head) + 1) % QUEUE_DEPTH);
    rd_count = rd_count - 1'b1;
  endtask

  task automatic dequeue_writer(output logic [ID_W-1:0] who);
    who      = wr_wait[wr_head];
    wr_head  = QPTR_W'((int'(wr_head) + 1) % QUEUE_DEPTH);
    wr_count = wr_count - 1'b1;
  endtask

  task automatic apply_lock_request(input op_t op, input logic [ID_W-1:0] who);
    logic [ID_W-1:0] woken;
    case (op)
      OP_ENTER_READ: begin
        // writer preference: any waiting writer blocks new readers
        if (wr_count != 0 || lock_writer) begin
          if (rd_count >= QUEUE_DEPTH) begin
            post_event(EV_FULL, who, 1'b1);
          end else begin
            enqueue_reader(who);
            post_event(EV_QUEUED, who, 1'b1);
          end
        end else if (lock_readers >= READER_LIMIT) begin
          post_event(EV_FULL, who, 1'b1);
        end else begin
          lock_readers = lock_readers + 1'b1;
          post_event(EV_GRANTED, who, 1'b1);
        end
      end
      OP_ENTER_WRITE: begin
        if (lock_readers != 0 || lock_writer) begin
          if (wr_count >= QUEUE_DEPTH) begin
            post_event(EV_FULL, who, 1'b1);
          end else begin
            enqueue_writer(who);
            post_event(EV_QUEUED, who, 1'b1);
          end
        end else begin
          lock_writer = 1'b1;
          post_event(EV_GRANTED, who, 1'b1);
        end
      end
      OP_EXIT_READ: begin
        if (lock_readers == 0) begin
          post_event(EV_NO_HOLDER, who, 1'b1);
        end else begin
          lock_readers = lock_readers - 1'b1;
          if (lock_readers == 0 && wr_count != 0) begin
            dequeue_writer(woken);
            lock_writer = 1'b1;
            post_event(EV_WRITER_WOKEN, woken, 1'b1);
          end else begin
            post_event(EV_RELEASED, who, 1'b1);
          end
        end
      end
      default: begin
        if (!lock_writer) begin
          post_event(EV_NO_HOLDER, who, 1'b1);
        end else begin
          lock_writer = 1'b0;
          if (rd_count == 0 && wr_count != 0) begin
            dequeue_writer(woken);
            lock_writer = 1'b1;
            post_event(EV_WRITER_WOKEN, woken, 1'b1);
          end else if (rd_count != 0) begin
            // whole reader queue drains, one result per reader
            while (rd_count != 0) begin
              dequeue_reader(woken);
              if (lock_readers < READER_LIMIT) lock_readers = lock_readers + 1'b1;
              post_event(EV_READER_WOKEN, woken, rd_count == 0);
            end
          end else begin
            post_event(EV_RELEASED, who, 1'b1);
          end
        end
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
    fails++;
    $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want_v, got_v);
  endtask

  task automatic check_result();
    lock_event_t want;
    n_res++;
    if (m_tdata[2:0] < 3'd7) hits[m_tdata[2:0]] = 1'b1;
    if (expected_events.size() == 0) begin
      fails++;
      $display("%0t: result with nothing expected: event_res %0d granted_id %0d", $time,
               m_tdata[2:0], m_tdata[8:3]);
    end else begin
      want = expected_events.pop_front();
      if (m_tdata[2:0] !== want.ev) report_mismatch("event_res", want.ev, m_tdata[2:0]);
      if (m_tdata[8:3] !== want.who) report_mismatch("granted_id", want.who, m_tdata[8:3]);
      if (m_tdata[15:9] !== want.readers)
        report_mismatch("readers_active", want.readers, m_tdata[15:9]);
      if (m_tdata[16] !== want.writer) report_mismatch("writer_active", want.writer, m_tdata[16]);
      if (m_tlast !== want.fin) report_mismatch("tlast", want.fin, m_tlast);
      if (m_tdata[M_DATA_W-1:OUT_FIELDS_W] !== '0)
        report_mismatch("tdata padding", 0, m_tdata[M_DATA_W-1:OUT_FIELDS_W]);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rd_head      = '0;
      rd_count     = '0;
      wr_head      = '0;
      wr_count     = '0;
      lock_readers = '0;
      lock_writer  = 1'b0;
      expected_events.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        n_req++;
        apply_lock_request(op_t'(s_tdata[OP_W-1:0]), s_tdata[OP_W +: ID_W]);
      end
      if (m_tvalid && m_tready) check_result();
    end
    fail_count    <= fails;
    pending       <= expected_events.size();
    requests_seen <= n_req;
    results_seen  <= n_res;
    codes_seen    <= hits;
    readers_held  <= lock_readers;
    writer_held   <= lock_writer;
  end

endmodule

// ----- tb/tb_readers_writer_lock_arbiter_core.sv -----
`timescale 1ns / 100ps

module tb_readers_writer_lock_arbiter_core;
  import rwl_pkg::*;

  localparam int TOTAL_ITEMS    = 460;
  localparam int QUIET_TAIL     = 50;
  localparam int WATCHDOG_LIMIT = 500;
  localparam int DRAIN_CYCLES   = 24;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  // [1:0] operation, [7:2] requester_id
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  // [2:0] event_res, [8:3] granted_id, [15:9] readers_active, [16] writer_active
  logic [M_DATA_W-1:0] m_tdata;
  logic                m_tlast;

  int               fail_count, pending, requests_seen, results_seen;
  logic [6:0]       codes_seen;
  logic [CNT_W-1:0] readers_held;
  logic             writer_held;

  int   items_sent = 0;
  int   tx_calm = 0;
  int   stall_left = 0;
  int   calm_left = 0;
  int   idle_cycles = 0;
  logic quiet = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  readers_writer_lock_arbiter_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  lock_event_checker u_chk (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .fail_count    (fail_count),
    .pending       (pending),
    .requests_seen (requests_seen),
    .results_seen  (results_seen),
    .codes_seen    (codes_seen),
    .readers_held  (readers_held),
    .writer_held   (writer_held)
  );

  // result side backpressure: random stall bursts with m_tready low, each followed by a ready
  // cycle, with calm stretches between
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (calm_left > 0) begin
      m_tready  <= 1'b1;
      calm_left <= calm_left - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 13);
      calm_left  <= 1;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 15) == 0) calm_left <= $urandom_range(10, 60);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(input op_t op, input logic [ID_W-1:0] who);
    int gap;
    gap = 0;
    if (tx_calm > 0) tx_calm--;
    else if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 14);
    else if ($urandom_range(0, 19) == 0) tx_calm = $urandom_range(5, 30);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {who, op};
    do @(posedge clk); while (s_tready !== 1'b1);
    items_sent++;
    if (items_sent >= TOTAL_ITEMS - QUIET_TAIL) quiet <= 1'b1;
  endtask

  // state seen here lags one transaction, so a spare exit may go out: harmless
  task automatic release_all();
    int guard;
    guard = 0;
    while ((readers_held != 0 || writer_held) && guard < 120) begin
      if (writer_held) send_request(OP_EXIT_WRITE, ID_W'($urandom_range(0, 63)));
      else send_request(OP_EXIT_READ, ID_W'($urandom_range(0, 63)));
      guard++;
    end
  endtask

  // writer takes the lock, then readers and writers pile up behind it
  task automatic pile_up(input int nr, input int nw);
    int r_left, w_left;
    release_all();
    send_request(OP_ENTER_WRITE, ID_W'($urandom_range(0, 63)));
    r_left = nr;
    w_left = nw;
    while (r_left + w_left > 0) begin
      if (r_left > 0 && (w_left == 0 || $urandom_range(0, 1) == 1)) begin
        send_request(OP_ENTER_READ, ID_W'($urandom_range(0, 63)));
        r_left--;
      end else begin
        send_request(OP_ENTER_WRITE, ID_W'($urandom_range(0, 63)));
        w_left--;
      end
    end
    release_all();
  endtask

  task automatic mixed_run(input int n, input bit wild);
    int   k, r;
    op_t  op;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (wild) op = op_t'($urandom_range(0, 3));
      else if (writer_held && r < 30) op = OP_EXIT_WRITE;
      else if (readers_held != 0 && r < 65) op = OP_EXIT_READ;
      else if (r < 82) op = OP_ENTER_READ;
      else op = OP_ENTER_WRITE;
      send_request(op, ID_W'($urandom_range(0, 63)));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // releases with no holder, then readers block a writer, which blocks a reader
    send_request(OP_EXIT_READ, 6'd0);
    send_request(OP_EXIT_WRITE, 6'd63);
    send_request(OP_ENTER_READ, 6'd0);
    send_request(OP_ENTER_READ, 6'd63);
    send_request(OP_ENTER_WRITE, 6'b101010);
    send_request(OP_ENTER_READ, 6'b010101);
    send_request(OP_EXIT_READ, 6'd0);
    send_request(OP_EXIT_READ, 6'd63);       // last reader out wakes the writer
    send_request(OP_ENTER_READ, 6'd5);
    send_request(OP_ENTER_WRITE, 6'd9);
    send_request(OP_EXIT_WRITE, 6'b101010);  // waiting readers win over waiting writer
    send_request(OP_EXIT_READ, 6'b010101);
    send_request(OP_EXIT_READ, 6'd5);
    send_request(OP_EXIT_WRITE, 6'd9);       // nobody waiting
    send_request(OP_ENTER_WRITE, 6'd1);
    send_request(OP_ENTER_WRITE, 6'd2);
    send_request(OP_EXIT_WRITE, 6'd1);       // writer to writer hand-off
    send_request(OP_EXIT_WRITE, 6'd2);

    // both queues overflow, then a full reader queue drains at once
    pile_up(QUEUE_DEPTH + 2, QUEUE_DEPTH + 2);

    // readers up to the count limit and past it
    release_all();
    repeat (READER_LIMIT + 3) send_request(OP_ENTER_READ, ID_W'($urandom_range(0, 63)));
    release_all();

    while (items_sent < TOTAL_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: mixed_run($urandom_range(6, 20), 1'b0);
        5, 6, 7: pile_up($urandom_range(0, QUEUE_DEPTH + 2), $urandom_range(0, QUEUE_DEPTH + 2));
        default: mixed_run($urandom_range(3, 10), 1'b1);
      endcase
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d lock requests and %0d checked results; event codes seen %b",
             requests_seen, results_seen, codes_seen);
    $display("including queue overflow, reader limit and full reader-queue drains");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
